[src/b64sc_pkg.sv]
package b64sc_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam int         RES_DEPTH = 4;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] ADDR_DECODE_MODE = 3'd0;

    typedef logic [7:0] byte_t;
    typedef logic [5:0] sextet_t;

    function automatic byte_t sextet_to_char(input sextet_t v);
        byte_t c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // Anything outside the alphabet maps to zero.
    function automatic sextet_t char_to_sextet(input byte_t c);
        byte_t s;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = c - 8'h30 + 8'd52;
        end else if (c == 8'h2B) begin
            s = 8'd62;
        end else if (c == 8'h2F) begin
            s = 8'd63;
        end else begin
            s = 8'd0;
        end
        return s[5:0];
    endfunction

endpackage

[src/base64_stream_codec.sv]
// Streaming Base64 codec (standard alphabet). decode_mode at address 0 selects
// encoding of data bytes into characters (0) or decoding of characters into
// bytes (1); writing it restarts the group. Each input item is worked out in
// the cycle it is accepted and its results are loaded into a four-entry
// result buffer that drains one item per cycle on the m_ side while m_ready
// is high. The buffer sets the rate: with m_ready high an input item is taken
// every cycle as long as each causes at most one result, so decoding runs at
// one character per cycle. In encoding every third byte gives two characters
// and a last item gives up to four, for a flush with two pad characters; a
// new item waits until the buffer is empty or its final result leaves. A last
// decode item yielding no byte gives one empty end marker with m_out_valid low.
module base64_stream_codec (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_out_valid,
    output logic        m_out_last
);

    localparam int DEPTH = b64sc_pkg::RES_DEPTH;

    logic                      mode_reg;
    logic [5:0]                carry_reg, carry_next;
    logic [1:0]                phase_reg, phase_next;
    b64sc_pkg::byte_t          byte_reg [DEPTH];
    b64sc_pkg::byte_t          byte_next [DEPTH];
    logic [DEPTH-1:0]          valid_reg, valid_next;
    logic                      last_reg;
    logic [2:0]                cnt_reg, cnt_next;

    logic cfg_write;
    logic in_fire;
    logic out_fire;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == b64sc_pkg::ADDR_DECODE_MODE);
    assign prdata    = (paddr == b64sc_pkg::ADDR_DECODE_MODE) ? {31'd0, mode_reg} : 32'd0;

    assign m_valid     = (cnt_reg != 3'd0);
    assign m_out_byte  = byte_reg[0];
    assign m_out_valid = valid_reg[0];
    assign m_out_last  = last_reg && (cnt_reg == 3'd1);

    assign out_fire = m_valid && m_ready;
    // Room for a new item once the buffer is empty or its final entry leaves now.
    assign s_ready  = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_ready);
    assign in_fire  = s_valid && s_ready;

    // Results of the incoming item and the state it leaves.
    always_comb begin
        logic [2:0]             n;
        b64sc_pkg::byte_t       b;
        b64sc_pkg::sextet_t     s;
        b = s_in_byte;
        s = b64sc_pkg::char_to_sextet(b);
        n = 3'd0;
        carry_next = carry_reg;
        phase_next = phase_reg;
        for (int i = 0; i < DEPTH; i++) begin
            byte_next[i] = 8'd0;
        end
        valid_next = '0;

        if (!mode_reg) begin
            case (phase_reg)
                2'd1: begin
                    byte_next[0] = b64sc_pkg::sextet_to_char(carry_reg | {2'b00, b[7:4]});
                    carry_next   = {b[3:0], 2'b00};
                    phase_next   = 2'd2;
                    n            = 3'd1;
                end
                2'd2: begin
                    byte_next[0] = b64sc_pkg::sextet_to_char(carry_reg | {4'd0, b[7:6]});
                    byte_next[1] = b64sc_pkg::sextet_to_char(b[5:0]);
                    carry_next   = 6'd0;
                    phase_next   = 2'd0;
                    n            = 3'd2;
                end
                default: begin
                    byte_next[0] = b64sc_pkg::sextet_to_char(b[7:2]);
                    carry_next   = {b[1:0], 4'd0};
                    phase_next   = 2'd1;
                    n            = 3'd1;
                end
            endcase
            if (s_in_last) begin
                if (phase_next == 2'd1) begin
                    byte_next[1] = b64sc_pkg::sextet_to_char(carry_next);
                    byte_next[2] = b64sc_pkg::PAD_CHAR;
                    byte_next[3] = b64sc_pkg::PAD_CHAR;
                    n            = 3'd4;
                end else if (phase_next == 2'd2) begin
                    byte_next[1] = b64sc_pkg::sextet_to_char(carry_next);
                    byte_next[2] = b64sc_pkg::PAD_CHAR;
                    n            = 3'd3;
                end
                carry_next = 6'd0;
                phase_next = 2'd0;
            end
            for (int i = 0; i < DEPTH; i++) begin
                valid_next[i] = (3'(i) < n);
            end
        end else begin
            if (b == b64sc_pkg::PAD_CHAR) begin
                carry_next = 6'd0;
                phase_next = 2'd0;
            end else begin
                case (phase_reg)
                    2'd0: begin
                        carry_next = s;
                        phase_next = 2'd1;
                    end
                    2'd1: begin
                        byte_next[0] = {carry_reg, s[5:4]};
                        carry_next   = {2'b00, s[3:0]};
                        phase_next   = 2'd2;
                        n            = 3'd1;
                    end
                    2'd2: begin
                        byte_next[0] = {carry_reg[3:0], s[5:2]};
                        carry_next   = {4'd0, s[1:0]};
                        phase_next   = 2'd3;
                        n            = 3'd1;
                    end
                    default: begin
                        byte_next[0] = {carry_reg[1:0], s};
                        carry_next   = 6'd0;
                        phase_next   = 2'd0;
                        n            = 3'd1;
                    end
                endcase
            end
            valid_next[0] = (n != 3'd0);
            if (s_in_last) begin
                // An empty end marker carries the last flag when no byte came out.
                n          = 3'd1;
                carry_next = 6'd0;
                phase_next = 2'd0;
            end
        end
        cnt_next = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            carry_reg <= 6'd0;
            phase_reg <= 2'd0;
            cnt_reg   <= 3'd0;
            valid_reg <= '0;
            last_reg  <= 1'b0;
        end else begin
            if (cfg_write) begin
                mode_reg  <= pwdata[0];
                carry_reg <= 6'd0;
                phase_reg <= 2'd0;
            end else if (in_fire) begin
                carry_reg <= carry_next;
                phase_reg <= phase_next;
            end

            if (in_fire) begin
                cnt_reg   <= cnt_next;
                valid_reg <= valid_next;
                last_reg  <= s_in_last;
            end else if (out_fire) begin
                cnt_reg   <= cnt_reg - 3'd1;
                valid_reg <= {1'b0, valid_reg[DEPTH-1:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            for (int i = 0; i < DEPTH; i++) begin
                byte_reg[i] <= byte_next[i];
            end
        end else if (out_fire) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                byte_reg[i] <= byte_reg[i+1];
            end
            byte_reg[DEPTH-1] <= 8'd0;
        end
    end

endmodule

[test/b64_codec_checker.sv]
`timescale 1ns / 1ps

// Watches the configuration port and both item channels of the codec, keeps its
// own copy of the mode and group state, and compares every result item with the
// oldest predicted one.
module b64_codec_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_out_valid,
    input  logic        m_out_last,
    output int          outstanding,
    output int          fail_count
);

    localparam logic [8*64-1:0] B64_SET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] ch;
        logic       has_data;
        logic       fin;
    } b64_sym_t;

    b64_sym_t   expected_syms[$];
    logic       decoding;
    logic [5:0] carry;
    logic [1:0] grp_phase;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        return B64_SET[8*(63 - v) +: 8];
    endfunction

    // Characters outside the alphabet fall through the search and count as zero.
    function automatic logic [5:0] b64_value(input logic [7:0] c);
        for (int i = 0; i < 64; i++) begin
            if (B64_SET[8*(63 - i) +: 8] == c) begin
                return i[5:0];
            end
        end
        return 6'd0;
    endfunction

    task automatic push_sym(input logic [7:0] c, input logic has_data);
        b64_sym_t sym;
        sym.ch = c;
        sym.has_data = has_data;
        sym.fin = 1'b0;
        expected_syms.insert(expected_syms.size(), sym);
    endtask

    task automatic codec_predict(input logic [7:0] b, input logic fin);
        int         n0;
        logic [5:0] s;
        n0 = expected_syms.size();
        if (!decoding) begin
            case (grp_phase)
                2'd1: begin
                    push_sym(b64_char(carry | {2'b00, b[7:4]}), 1'b1);
                    carry = {b[3:0], 2'b00};
                    grp_phase = 2'd2;
                end
                2'd2: begin
                    push_sym(b64_char(carry | {4'b0000, b[7:6]}), 1'b1);
                    push_sym(b64_char(b[5:0]), 1'b1);
                    carry = '0;
                    grp_phase = 2'd0;
                end
                default: begin
                    push_sym(b64_char(b[7:2]), 1'b1);
                    carry = {b[1:0], 4'b0000};
                    grp_phase = 2'd1;
                end
            endcase
            if (fin) begin
                if (grp_phase == 2'd1) begin
                    push_sym(b64_char(carry), 1'b1);
                    push_sym(b64sc_pkg::PAD_CHAR, 1'b1);
                    push_sym(b64sc_pkg::PAD_CHAR, 1'b1);
                end else if (grp_phase == 2'd2) begin
                    push_sym(b64_char(carry), 1'b1);
                    push_sym(b64sc_pkg::PAD_CHAR, 1'b1);
                end
                carry = '0;
                grp_phase = 2'd0;
            end
        end else begin
            if (b == b64sc_pkg::PAD_CHAR) begin
                carry = '0;
                grp_phase = 2'd0;
            end else begin
                s = b64_value(b);
                case (grp_phase)
                    2'd0: begin
                        carry = s;
                        grp_phase = 2'd1;
                    end
                    2'd1: begin
                        push_sym({carry, s[5:4]}, 1'b1);
                        carry = {2'b00, s[3:0]};
                        grp_phase = 2'd2;
                    end
                    2'd2: begin
                        push_sym({carry[3:0], s[5:2]}, 1'b1);
                        carry = {4'b0000, s[1:0]};
                        grp_phase = 2'd3;
                    end
                    default: begin
                        push_sym({carry[1:0], s}, 1'b1);
                        carry = '0;
                        grp_phase = 2'd0;
                    end
                endcase
            end
            if (fin) begin
                // A closing item that completes no byte still produces an end marker.
                if (expected_syms.size() == n0) begin
                    push_sym(8'h00, 1'b0);
                end
                carry = '0;
                grp_phase = 2'd0;
            end
        end
        if (fin && expected_syms.size() > n0) begin
            expected_syms[expected_syms.size() - 1].fin = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        b64_sym_t want;
        b64_sym_t got;
        if (!aresetn) begin
            decoding = 1'b0;
            carry = '0;
            grp_phase = 2'd0;
            expected_syms.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == b64sc_pkg::ADDR_DECODE_MODE) begin
                decoding = pwdata[0];
                carry = '0;
                grp_phase = 2'd0;
            end
            if (s_valid && s_ready) begin
                codec_predict(s_in_byte, s_in_last);
            end
            if (m_valid && m_ready) begin
                got.ch = m_out_byte;
                got.has_data = m_out_valid;
                got.fin = m_out_last;
                if (expected_syms.size() == 0) begin
                    $display("%0t: unexpected result item: byte %h valid %b last %b",
                             $time, got.ch, got.has_data, got.fin);
                    fail_count++;
                end else begin
                    want = expected_syms.pop_front();
                    if (want.ch !== got.ch || want.has_data !== got.has_data ||
                        want.fin !== got.fin) begin
                        $display("%0t: expected byte %h valid %b last %b, %s %h %s %b %s %b",
                                 $time, want.ch, want.has_data, want.fin,
                                 "got byte", got.ch, "valid", got.has_data,
                                 "last", got.fin);
                        fail_count++;
                    end
                end
            end
        end
        outstanding <= expected_syms.size();
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam logic [31:0] MODE_ENCODE = 32'd0;
    localparam logic [31:0] MODE_DECODE = 32'd1;
    localparam logic [2:0]  ADDR_UNUSED = 3'd4;
    localparam int          HOLD_CYCLES = 400;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          PHASE_ITEMS = 45;
    localparam logic [8*64-1:0] B64_SET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_in_last;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_out_valid;
    logic        m_out_last;

    int   outstanding;
    int   fail_count;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_count = 0;
    int   cycle_count = 0;
    int   items_sent = 0;
    logic long_hold = 1'b0;

    always #2 aclk = ~aclk;

    base64_stream_codec dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_valid (m_out_valid),
        .m_out_last  (m_out_last)
    );

    b64_codec_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_valid (m_out_valid),
        .m_out_last  (m_out_last),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // Result side: random stalls, plus one long hold-off so the codec backs up
    // and has to drop s_ready.
    always @(posedge aclk) begin
        if (long_hold && hold_count < HOLD_CYCLES) begin
            m_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_item(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_in_last <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Well-formed encoded text of whole groups, the final group padded by
    // pad_cnt '=' characters; an occasional message is left without its last.
    task automatic send_text(input int groups, input int pad_cnt, input logic close);
        logic [7:0] c;
        for (int g = 0; g < groups; g++) begin
            for (int k = 0; k < 4; k++) begin
                c = B64_SET[8*(63 - $urandom_range(63)) +: 8];
                if (g == groups - 1 && k >= 4 - pad_cnt) begin
                    c = b64sc_pkg::PAD_CHAR;
                end
                send_item(c, close && g == groups - 1 && k == 3);
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] mode, input int idle_pct,
                             input int stall_pct, input logic hold);
        int start;
        int len;
        wait_drained();
        apb_write(b64sc_pkg::ADDR_DECODE_MODE, mode);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        if (hold) begin
            long_hold <= 1'b1;
        end
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            if (mode == MODE_ENCODE) begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    send_item(8'($urandom_range(255)),
                              i == len - 1 && $urandom_range(7) != 0);
                end
            end else if ($urandom_range(9) < 7) begin
                send_text($urandom_range(1, 4), $urandom_range(2), $urandom_range(7) != 0);
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    send_item(8'($urandom_range(255)), $urandom_range(7) == 0);
                end
            end
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_valid <= 1'b0;
        s_in_byte <= '0;
        s_in_last <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A write to an unmapped address must leave the codec encoding.
        apb_write(ADDR_UNUSED, MODE_DECODE);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'hFB, 1'b0);
        send_item(8'hEF, 1'b0);
        send_item(8'hBE, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b1);

        wait_drained();
        apb_write(b64sc_pkg::ADDR_DECODE_MODE, MODE_DECODE);
        send_item("T", 1'b0);
        send_item("W", 1'b0);
        send_item("F", 1'b0);
        send_item("u", 1'b0);
        send_item("+", 1'b0);
        send_item("/", 1'b0);
        send_item("9", 1'b0);
        send_item("z", 1'b0);
        // Padding at the start of a group does nothing.
        send_item(b64sc_pkg::PAD_CHAR, 1'b0);
        send_item("Q", 1'b0);
        send_item(b64sc_pkg::PAD_CHAR, 1'b0);
        send_item(b64sc_pkg::PAD_CHAR, 1'b1);
        // Bytes outside the alphabet decode as zero.
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item("A", 1'b0);
        send_item("#", 1'b1);
        // A lone character at the end leaves only an empty end marker.
        send_item("Q", 1'b1);
        send_item("T", 1'b0);

        run_phase(MODE_ENCODE, 0, 0, 1'b0);
        run_phase(MODE_DECODE, 87, 0, 1'b0);
        run_phase(MODE_DECODE, 0, 87, 1'b0);
        run_phase(MODE_ENCODE, 38, 38, 1'b0);
        run_phase(MODE_ENCODE, 0, 0, 1'b1);
        run_phase(MODE_DECODE, 38, 38, 1'b0);
        wait_drained();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
src/b64sc_pkg.sv
src/base64_stream_codec.sv
test/b64_codec_checker.sv
test/tb_top.sv
